// ===== hdl/q2e_pkg.sv =====
package q2e_pkg;

    localparam int QW               = 16;
    localparam int PROD_W           = 2 * QW;
    localparam int TERM_W           = PROD_W + 2;
    localparam int S_W              = 32;
    localparam int MAG_W            = S_W - 1;
    localparam int SQ_W             = 62;
    localparam int ROOT_W           = 31;
    localparam int SQRT_STEPS       = 31;
    localparam int CW               = 52;
    localparam int ZW               = 26;
    localparam int SH_W             = 5;
    localparam int STEP_W           = 22;
    localparam int PRESCALE_SH      = 16;
    localparam int ROUND_SH         = 9;
    localparam int RW               = ZW - ROUND_SH;
    localparam int PITCH_W          = 15;
    localparam int ANGLE_W          = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ANGLE_ITERATIONS = 16;

    // Front stages (products, sums, square), root chain, CORDIC entry,
    // CORDIC cells, output register.
    localparam int DEPTH = 3 + SQRT_STEPS + 1 + ANGLE_ITERATIONS + 1;

    localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(64'sd1 <<< 30);
    localparam logic [SQ_W-1:0]          ONE_Q60 = SQ_W'(64'd1 << 60);
    localparam logic signed [ZW-1:0]     DEG180  = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0]     ROUND_HALF = ZW'(256);
    localparam logic signed [RW-1:0]     PITCH_LIM = RW'(11520);
    localparam logic signed [RW-1:0]     ANGLE_LIM = RW'(23040);

    // atan(2^-i) in degrees, times 65536
    localparam logic [STEP_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] sbit;
    } sq_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic signed [S_W-1:0]    s;
        logic signed [TERM_W-1:0] roll_y;
        logic signed [TERM_W-1:0] roll_x;
        logic signed [TERM_W-1:0] yaw_y;
        logic signed [TERM_W-1:0] yaw_x;
    } side_t;

endpackage

// ===== hdl/q2e_sqrt_cell.sv =====
module q2e_sqrt_cell (
    input  logic         clk,
    input  logic         en,
    input  q2e_pkg::sq_t din,
    output q2e_pkg::sq_t dout
);
    import q2e_pkg::*;

    sq_t             cell_reg;
    sq_t             cell_next;
    logic [SQ_W-1:0] trial;

    // One restoring step: two radicand bits, one root bit.
    always_comb
    begin
        trial     = din.root + din.sbit;
        cell_next = din;
        if (din.n >= trial)
        begin
            cell_next.n    = din.n - trial;
            cell_next.root = (din.root >> 1) + din.sbit;
        end
        else
        begin
            cell_next.root = din.root >> 1;
        end
        cell_next.sbit = din.sbit >> 2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== hdl/q2e_cordic_cell.sv =====
module q2e_cordic_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [q2e_pkg::SH_W-1:0]     shift,
    input  logic [q2e_pkg::STEP_W-1:0]   step,
    input  q2e_pkg::lane_t               din,
    output q2e_pkg::lane_t               dout
);
    import q2e_pkg::*;

    lane_t                cell_reg;
    lane_t                cell_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] dz;

    always_comb
    begin
        dx = din.y >>> shift;
        dy = din.x >>> shift;
        dz = $signed(ZW'(step));
        if (din.y > 0)
        begin
            cell_next.x = din.x + dx;
            cell_next.y = din.y - dy;
            cell_next.z = din.z + dz;
        end
        else
        begin
            cell_next.x = din.x - dx;
            cell_next.y = din.y + dy;
            cell_next.z = din.z - dz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// ===== hdl/quaternion_to_euler.sv =====
// Quaternion to aerospace Euler angles. One quaternion (w, x, y, z, signed
// Q1.15) is taken per clock while quat_stall is low, and pitch, roll and
// yaw come out in degrees times 128, rounded to nearest and saturated to
// +-90 and +-180 degrees. The block is a straight pipeline of 52 register
// stages: the front stages of products, sums and the square, a chain of 31
// square-root cells for the pitch cosine, a CORDIC entry stage, 16 CORDIC
// cells per angle and the output register. The whole pipeline holds while a
// result waits under stall, so quat_stall follows angle_valid and
// angle_stall in the same cycle.
// Non-unit quaternions are processed as they are.
module quaternion_to_euler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               quat_valid,
    output logic                               quat_stall,
    input  logic signed [q2e_pkg::QW-1:0]      quat_w,
    input  logic signed [q2e_pkg::QW-1:0]      quat_x,
    input  logic signed [q2e_pkg::QW-1:0]      quat_y,
    input  logic signed [q2e_pkg::QW-1:0]      quat_z,
    output logic                               angle_valid,
    input  logic                               angle_stall,
    output logic signed [q2e_pkg::PITCH_W-1:0] pitch_angle,
    output logic signed [q2e_pkg::ANGLE_W-1:0] roll_angle,
    output logic signed [q2e_pkg::ANGLE_W-1:0] yaw_angle
);
    import q2e_pkg::*;

    localparam int NL = 3;

    function automatic lane_t lane_init(input logic signed [TERM_W-1:0] ys,
                                        input logic signed [TERM_W-1:0] xc);
        lane_t                l;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] yss;
        xs  = CW'(xc) <<< PRESCALE_SH;
        yss = CW'(ys) <<< PRESCALE_SH;
        if (xs < 0)
        begin
            l.z = (ys >= 0) ? DEG180 : -DEG180;
            l.x = -xs;
            l.y = -yss;
        end
        else
        begin
            l.z = '0;
            l.x = xs;
            l.y = yss;
        end
        return l;
    endfunction

    function automatic logic signed [RW-1:0] to_angle(input logic signed [ZW-1:0] z,
                                                      input logic signed [RW-1:0] lim);
        logic signed [ZW-1:0] zr;
        logic signed [RW-1:0] r;
        zr = (z + ROUND_HALF) >>> ROUND_SH;
        r  = RW'(zr);
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    logic en;
    logic vld_reg [DEPTH];

    // Stage 1: products
    logic signed [PROD_W-1:0] wy_reg, zx_reg, wx_reg, yz_reg, wz_reg, xy_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg;

    // Stage 2: terms
    logic signed [TERM_W-1:0] ds;
    logic signed [TERM_W-1:0] sc;
    logic signed [S_W-1:0]    s_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [TERM_W-1:0] roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;

    // Stage 3: square of the pitch sine
    logic [SQ_W-1:0] s2_reg;
    side_t           side3_reg;

    // Root chain
    sq_t   sq_w [SQRT_STEPS+1];
    side_t side_reg [SQRT_STEPS];

    // CORDIC lanes: pitch, roll, yaw
    lane_t                      cr_w [NL][ANGLE_ITERATIONS+1];
    logic [NL-1:0]              zf_reg [ANGLE_ITERATIONS+1];
    logic signed [TERM_W-1:0]   pitch_y;
    logic signed [TERM_W-1:0]   pitch_x;
    side_t                      side_last;

    logic signed [PITCH_W-1:0]  pitch_reg;
    logic signed [ANGLE_W-1:0]  roll_reg;
    logic signed [ANGLE_W-1:0]  yaw_reg;

    assign angle_valid = vld_reg[DEPTH-1];
    assign quat_stall  = angle_valid & angle_stall;
    assign en          = ~quat_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= quat_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
        end
    end

    // The pitch sine is clamped to [-1, 1] before the arcsine.
    always_comb
    begin
        ds = (TERM_W'(wy_reg) - TERM_W'(zx_reg)) <<< 1;
        if (ds > ONE_Q30)
        begin
            sc = ONE_Q30;
        end
        else if (ds < -ONE_Q30)
        begin
            sc = -ONE_Q30;
        end
        else
        begin
            sc = ds;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= S_W'(sc);
            mag_reg    <= (sc < 0) ? MAG_W'(-sc) : MAG_W'(sc);
            roll_y_reg <= (TERM_W'(wx_reg) + TERM_W'(yz_reg)) <<< 1;
            roll_x_reg <= ONE_Q30 - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
            yaw_y_reg  <= (TERM_W'(wz_reg) + TERM_W'(xy_reg)) <<< 1;
            yaw_x_reg  <= ONE_Q30 - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg           <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
            side3_reg.s      <= s_reg;
            side3_reg.roll_y <= roll_y_reg;
            side3_reg.roll_x <= roll_x_reg;
            side3_reg.yaw_y  <= yaw_y_reg;
            side3_reg.yaw_x  <= yaw_x_reg;
        end
    end

    assign sq_w[0].n    = ONE_Q60 - s2_reg;
    assign sq_w[0].root = '0;
    assign sq_w[0].sbit = ONE_Q60;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .clk  (clk),
            .en   (en),
            .din  (sq_w[k]),
            .dout (sq_w[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side3_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_last = side_reg[SQRT_STEPS-1];
    assign pitch_y   = TERM_W'(side_last.s);
    assign pitch_x   = $signed(TERM_W'(sq_w[SQRT_STEPS].root[ROOT_W-1:0]));

    // CORDIC entry: prescale, fold the left half plane, flag a zero vector.
    lane_t pre_reg [NL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg[0]   <= lane_init(pitch_y, pitch_x);
            pre_reg[1]   <= lane_init(side_last.roll_y, side_last.roll_x);
            pre_reg[2]   <= lane_init(side_last.yaw_y, side_last.yaw_x);
            zf_reg[0][0] <= (pitch_y == 0) && (pitch_x == 0);
            zf_reg[0][1] <= (side_last.roll_y == 0) && (side_last.roll_x == 0);
            zf_reg[0][2] <= (side_last.yaw_y == 0) && (side_last.yaw_x == 0);
            for (int i = 1; i <= ANGLE_ITERATIONS; i++)
            begin
                zf_reg[i] <= zf_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        assign cr_w[l][0] = pre_reg[l];
        for (genvar k = 0; k < ANGLE_ITERATIONS; k++)
        begin : g_cell
            q2e_cordic_cell u_cell (
                .clk   (clk),
                .en    (en),
                .shift (SH_W'(k)),
                .step  (ATAN_TAB[k]),
                .din   (cr_w[l][k]),
                .dout  (cr_w[l][k+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= zf_reg[ANGLE_ITERATIONS][0] ? '0 :
                         PITCH_W'(to_angle(cr_w[0][ANGLE_ITERATIONS].z, PITCH_LIM));
            roll_reg  <= zf_reg[ANGLE_ITERATIONS][1] ? '0 :
                         ANGLE_W'(to_angle(cr_w[1][ANGLE_ITERATIONS].z, ANGLE_LIM));
            yaw_reg   <= zf_reg[ANGLE_ITERATIONS][2] ? '0 :
                         ANGLE_W'(to_angle(cr_w[2][ANGLE_ITERATIONS].z, ANGLE_LIM));
        end
    end

    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign yaw_angle   = yaw_reg;

endmodule

// ===== hdl/q2e_checker.sv =====
module q2e_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               quat_valid,
    input logic                               quat_stall,
    input logic signed [q2e_pkg::QW-1:0]      quat_w,
    input logic signed [q2e_pkg::QW-1:0]      quat_x,
    input logic signed [q2e_pkg::QW-1:0]      quat_y,
    input logic signed [q2e_pkg::QW-1:0]      quat_z,
    input logic                               angle_valid,
    input logic                               angle_stall,
    input logic signed [q2e_pkg::PITCH_W-1:0] pitch_angle,
    input logic signed [q2e_pkg::ANGLE_W-1:0] roll_angle,
    input logic signed [q2e_pkg::ANGLE_W-1:0] yaw_angle
);
    import q2e_pkg::*;

    // The input side only holds off while a finished item is being refused.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        quat_stall |-> (angle_valid && angle_stall))
        else $error("input stalled without a waiting result");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (pitch_angle <= 11520 && pitch_angle >= -11520))
        else $error("pitch out of range");

    a_roll_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (roll_angle <= 23040 && roll_angle >= -23040 &&
                         yaw_angle <= 23040 && yaw_angle >= -23040))
        else $error("roll or yaw out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && angle_stall) |=>
            (angle_valid && $stable(pitch_angle) && $stable(roll_angle) &&
             $stable(yaw_angle)))
        else $error("stalled result changed");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (.*);

// ===== tb/angle_checker.sv =====
`timescale 1ns / 1ps

module angle_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               quat_valid,
    input  logic                               quat_stall,
    input  logic signed [q2e_pkg::QW-1:0]      quat_w,
    input  logic signed [q2e_pkg::QW-1:0]      quat_x,
    input  logic signed [q2e_pkg::QW-1:0]      quat_y,
    input  logic signed [q2e_pkg::QW-1:0]      quat_z,
    input  logic                               angle_valid,
    input  logic                               angle_stall,
    input  logic signed [q2e_pkg::PITCH_W-1:0] pitch_angle,
    input  logic signed [q2e_pkg::ANGLE_W-1:0] roll_angle,
    input  logic signed [q2e_pkg::ANGLE_W-1:0] yaw_angle,
    output int                                 errors,
    output int                                 pending
);

    import q2e_pkg::*;

    typedef struct {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] yaw;
    } euler_t;

    localparam longint ONE30 = 64'sd1 <<< 30;
    localparam longint HALF_TURN = 64'sd180 * 65536;

    euler_t angles_due[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - res - b;
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    // Vectoring rotation; the angle builds up in degrees times 65536.
    function automatic longint vector_angle(longint ys, longint xc);
        longint x, y, z, dx, dy;
        if (ys == 0 && xc == 0)
            return 0;
        x = xc * 65536;
        y = ys * 65536;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ANGLE_ITERATIONS && i < TABLE_LEN; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint round_sat(longint z, longint lim);
        longint r;
        r = floor_sh(z + 256, 9);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
        euler_t e;
        longint s, m, c;
        s = 2 * (w * y - z * x);
        if (s > ONE30)
            s = ONE30;
        if (s < -ONE30)
            s = -ONE30;
        m = (s < 0) ? -s : s;
        c = int_sqrt((64'sd1 <<< 60) - m * m);
        e.pitch = PITCH_W'(round_sat(vector_angle(s, c), 11520));
        e.roll = ANGLE_W'(round_sat(vector_angle(2 * (w * x + y * z),
                                                  ONE30 - 2 * (x * x + y * y)), 23040));
        e.yaw = ANGLE_W'(round_sat(vector_angle(2 * (w * z + x * y),
                                                 ONE30 - 2 * (y * y + z * z)), 23040));
        return e;
    endfunction

    assign pending = angles_due.size();

    always @(posedge clk)
    begin
        euler_t e;
        if (!rst_n)
            errors = 0;
        else
        begin
            if (quat_valid && !quat_stall)
                angles_due.push_back(quat_to_euler(quat_w, quat_x, quat_y, quat_z));
            if (angle_valid && !angle_stall)
            begin
                if (angles_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %0d %0d %0d", $time,
                             pitch_angle, roll_angle, yaw_angle);
                end
                else
                begin
                    e = angles_due.pop_front();
                    if (pitch_angle !== e.pitch)
                    begin
                        errors++;
                        $display("%0t: pitch expected %0d actual %0d", $time,
                                 e.pitch, pitch_angle);
                    end
                    if (roll_angle !== e.roll)
                    begin
                        errors++;
                        $display("%0t: roll expected %0d actual %0d", $time,
                                 e.roll, roll_angle);
                    end
                    if (yaw_angle !== e.yaw)
                    begin
                        errors++;
                        $display("%0t: yaw expected %0d actual %0d", $time,
                                 e.yaw, yaw_angle);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import q2e_pkg::*;

    logic clk;
    logic rst_n;
    logic quat_valid;
    logic quat_stall;
    logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic angle_valid;
    logic angle_stall;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle, yaw_angle;
    int errors;
    int pending;
    int calm;
    bit hold_off_done;

    quaternion_to_euler uut (.*);

    angle_checker checker_i (.*);

    initial clk = 0;
    always #4 clk = ~clk;

    initial
    begin
        #50ms;
        $display("FAIL quaternion_to_euler");
        $finish;
    end

    // Quiet stretch first (no idling), then random idling, with one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            angle_stall <= 0;
        else if (!hold_off_done && calm > 400)
        begin
            angle_stall <= 1;
            repeat (200) @(negedge clk);
            hold_off_done = 1;
            angle_stall <= 0;
        end
        else
            angle_stall <= (calm < 300) ? 0 : ($urandom_range(99) < 38);
    end

    // The stall is read after the falling edge has settled, so it is the
    // value that the next rising edge will see.
    task automatic send_quat(logic [QW-1:0] w, logic [QW-1:0] x,
                             logic [QW-1:0] y, logic [QW-1:0] z);
        while (calm >= 300 && $urandom_range(99) < 38)
        begin
            quat_valid <= 0;
            @(negedge clk);
        end
        quat_valid <= 1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        #1;
        while (quat_stall)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        calm++;
        @(negedge clk);
    endtask

    // A quaternion with random components within about +-0.707 each, sometimes near gimbal lock.
    task automatic send_rotation();
        int w, x, y, z;
        w = $urandom_range(46341) - 23170;
        y = $urandom_range(46341) - 23170;
        x = $urandom_range(46341) - 23170;
        z = $urandom_range(46341) - 23170;
        if ($urandom_range(7) == 0)
        begin
            w = 23170 + $urandom_range(8) - 4;
            y = 23170 + $urandom_range(8) - 4;
            x = $urandom_range(64) - 32;
            z = $urandom_range(64) - 32;
        end
        send_quat(QW'(w), QW'(x), QW'(y), QW'(z));
    endtask

    initial
    begin
        calm = 0;
        hold_off_done = 0;
        rst_n = 0;
        quat_valid = 0;
        quat_w = 0;
        quat_x = 0;
        quat_y = 0;
        quat_z = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_quat(0, 0, 0, 0);
        send_quat(16'h7FFF, 0, 0, 0);
        send_quat(16'h8000, 0, 0, 0);
        send_quat(0, 16'h7FFF, 0, 0);
        send_quat(0, 0, 16'h7FFF, 0);
        send_quat(0, 0, 0, 16'h7FFF);
        send_quat(23170, 0, 23170, 0);
        send_quat(23170, 0, -23170, 0);
        send_quat(23170, 23170, 0, 0);
        send_quat(23170, 0, 0, 23170);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_quat(16'h7FFF, 0, 16'h7FFF, 0);
        send_quat(0, 23170, 0, 23170);
        send_quat(0, 23170, 23170, 0);
        send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_quat(1, 1, 1, 1);
        send_quat(0, 0, 0, 16'h8000);

        for (int i = 0; i < 1430; i++)
        begin
            if ($urandom_range(3) == 0)
                send_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
            else
                send_rotation();
        end
        quat_valid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS quaternion_to_euler");
        else
            $display("FAIL quaternion_to_euler");
        $finish;
    end

endmodule
